// ===== src/lrcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrcc_pkg: shared types and constants for the LED ring comet chase
// Configuration record, arithmetic unit request/response, sequencer codes,
// comet tail weight table.
// ----------------------------------------------------------------------------
package lrcc_pkg;

  localparam int PIXELS_DEF = 24;   // default ring length
  localparam int IdxW       = 6;    // pixel index / head width
  localparam int ChW        = 8;    // colour channel width
  localparam int PctW       = 7;    // percent register width
  localparam int AddrW      = 5;    // APB byte address width (8 regs x 4 bytes)
  localparam int TailLen    = 6;    // comet tail length in pixels
  localparam int TailW      = 3;    // index into the tail table
  localparam int NumCh      = 3;    // red, green, blue

  localparam logic [ChW-1:0]  ChaseLevel = 8'd35;
  localparam logic [PctW-1:0] PctFull    = 7'd100;

  // register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_IDLE_RED    = 3'd0,
    REG_IDLE_GREEN  = 3'd1,
    REG_IDLE_BLUE   = 3'd2,
    REG_PULSE_RED   = 3'd3,
    REG_PULSE_GREEN = 3'd4,
    REG_PULSE_BLUE  = 3'd5,
    REG_BRIGHTNESS  = 3'd6,
    REG_BOARD_SCALE = 3'd7
  } reg_idx_e;

  typedef enum logic [0:0] {
    DIV_BY_100 = 1'b0,
    DIV_BY_255 = 1'b1
  } div_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BR   = 5'b00010,
    ST_LVL  = 5'b00100,
    ST_CALC = 5'b01000,
    ST_EMIT = 5'b10000
  } seq_state_e;

  typedef struct packed {
    logic [ChW-1:0]  idle_red;
    logic [ChW-1:0]  idle_green;
    logic [ChW-1:0]  idle_blue;
    logic [ChW-1:0]  pulse_red;
    logic [ChW-1:0]  pulse_green;
    logic [ChW-1:0]  pulse_blue;
    logic [PctW-1:0] brightness;
    logic [PctW-1:0] board_scale;
  } cfg_t;

  // request into the multiply/divide unit: q = sat8((a*b)/K)
  typedef struct packed {
    logic           go;
    div_sel_e       sel;
    logic [ChW-1:0] a;
    logic [ChW-1:0] b;
  } mdu_req_t;

  typedef struct packed {
    logic           done;
    logic [ChW-1:0] q;
  } mdu_rsp_t;

  // 255*(6-d)/6 for d inside the tail
  function automatic logic [ChW-1:0] tail_weight(input logic [TailW-1:0] d);
    logic [ChW-1:0] w;
    case (d)
      3'd0:    w = 8'd255;
      3'd1:    w = 8'd212;
      3'd2:    w = 8'd170;
      3'd3:    w = 8'd127;
      3'd4:    w = 8'd85;
      3'd5:    w = 8'd42;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== src/led_ring_comet_chase.sv =====
// ----------------------------------------------------------------------------
// led_ring_comet_chase: comet chase / nightlight pixel generator for an LED ring
// Per tick: brightness and chase level through the multiply/divide unit, then
//   the idle or tail colours, then one pixel word per cycle for PIXELS words
//   while m_axis_tready allows; a new tick is taken only after the last word.
//   All arithmetic goes through the single shared multiply/divide unit.
// Reset: asynchronous, active low; head at pixel 0, colours and percents at
//   their register defaults, output stream empty.
// ----------------------------------------------------------------------------
module led_ring_comet_chase
  import lrcc_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF   // ring length, 2..64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // tick stream in
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [0] pulse_on, [7:1] zero
  // pixel stream out
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [5:0] pixel_index, [13:6] red,
                                           // [21:14] green, [29:22] blue, [31:30] zero
  output logic             m_axis_tlast,   // last_pixel
  // APB configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t            cfg;
  mdu_req_t        mdu_req;
  mdu_rsp_t        mdu_rsp;
  logic [IdxW-1:0] px_index;
  logic [ChW-1:0]  px_red, px_green, px_blue;

  // register file; the user must write it only between ticks, the block does not enforce this
  lrcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // shared multiply + constant divide, 2 register stages
  lrcc_mul_div u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  // per tick: br = bright*scale/100, lvl = br*35/100, then either the three idle
  // channels or the 6x3 tail colour table, then the pixel sweep
  lrcc_seq #(
    .PIXELS (PIXELS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .s_valid_i (s_axis_tvalid),
    .s_pulse_i (s_axis_tdata[0]),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_index_o (px_index),
    .m_red_o   (px_red),
    .m_green_o (px_green),
    .m_blue_o  (px_blue),
    .m_last_o  (m_axis_tlast),
    .mdu_req_o (mdu_req),
    .mdu_rsp_i (mdu_rsp)
  );

  assign m_axis_tdata = {2'b00, px_blue, px_green, px_red, px_index};

endmodule

// ===== src/lrcc_mul_div.sv =====
// ----------------------------------------------------------------------------
// lrcc_mul_div: shared 8x8 multiply followed by a constant divide
// Two register stages: product, then quotient by 100 or 255, saturated to 8 bits.
// ----------------------------------------------------------------------------
module lrcc_mul_div
  import lrcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mdu_req_t req_i,
  output mdu_rsp_t rsp_o
);

  logic            v1_q;
  logic            done_q;
  logic [15:0]     prod_q;
  div_sel_e        sel_q;
  logic [ChW-1:0]  q_q;

  logic [16:0]     sum255;
  logic [8:0]      quo255;
  logic [28:0]     mul100;
  logic [9:0]      quo100;
  logic [9:0]      quo;

  // x/255 exact for any 8x8 product x: (x + (x>>8) + 1) >> 8
  assign sum255 = {1'b0, prod_q} + {9'd0, prod_q[15:8]} + 17'd1;
  assign quo255 = sum255[16:8];

  // x/100 by reciprocal 5243/2^19, exact over the operand range used here
  assign mul100 = 29'(prod_q) * 29'(5243);
  assign quo100 = mul100[28:19];

  assign quo = (sel_q == DIV_BY_255) ? {1'b0, quo255} : quo100;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= req_i.go;
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      prod_q <= {8'd0, req_i.a} * {8'd0, req_i.b};
      sel_q  <= req_i.sel;
    end
    if (v1_q) begin
      q_q <= (quo > 10'd255) ? 8'hFF : quo[ChW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = q_q;

endmodule

// ===== src/lrcc_cfg.sv =====
// ----------------------------------------------------------------------------
// lrcc_cfg: APB register file for colours and brightness
// Zero wait state; brightness writes above 100 clamp to 100.
// ----------------------------------------------------------------------------
module lrcc_cfg
  import lrcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t           cfg_q;
  logic           wr_en;
  reg_idx_e       idx;
  logic [PctW-1:0] wr7;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr7    = pwdata[PctW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_red    <= '0;
      cfg_q.idle_green  <= '0;
      cfg_q.idle_blue   <= '0;
      cfg_q.pulse_red   <= '0;
      cfg_q.pulse_green <= '0;
      cfg_q.pulse_blue  <= 8'd255;
      cfg_q.brightness  <= PctFull;
      cfg_q.board_scale <= PctFull;
    end else if (wr_en) begin
      case (idx)
        REG_IDLE_RED:    cfg_q.idle_red    <= pwdata[ChW-1:0];
        REG_IDLE_GREEN:  cfg_q.idle_green  <= pwdata[ChW-1:0];
        REG_IDLE_BLUE:   cfg_q.idle_blue   <= pwdata[ChW-1:0];
        REG_PULSE_RED:   cfg_q.pulse_red   <= pwdata[ChW-1:0];
        REG_PULSE_GREEN: cfg_q.pulse_green <= pwdata[ChW-1:0];
        REG_PULSE_BLUE:  cfg_q.pulse_blue  <= pwdata[ChW-1:0];
        REG_BRIGHTNESS:  cfg_q.brightness  <= (wr7 > PctFull) ? PctFull : wr7;
        REG_BOARD_SCALE: cfg_q.board_scale <= wr7;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IDLE_RED:    prdata = {24'd0, cfg_q.idle_red};
      REG_IDLE_GREEN:  prdata = {24'd0, cfg_q.idle_green};
      REG_IDLE_BLUE:   prdata = {24'd0, cfg_q.idle_blue};
      REG_PULSE_RED:   prdata = {24'd0, cfg_q.pulse_red};
      REG_PULSE_GREEN: prdata = {24'd0, cfg_q.pulse_green};
      REG_PULSE_BLUE:  prdata = {24'd0, cfg_q.pulse_blue};
      REG_BRIGHTNESS:  prdata = {25'd0, cfg_q.brightness};
      REG_BOARD_SCALE: prdata = {25'd0, cfg_q.board_scale};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/lrcc_seq.sv =====
// ----------------------------------------------------------------------------
// lrcc_seq: tick sequencer and pixel emitter
// Drives the shared multiply/divide unit to build the scale factors and the
// per-tick colour table, then streams one pixel word per cycle while m_ready_i allows.
// ----------------------------------------------------------------------------
module lrcc_seq
  import lrcc_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            s_valid_i,
  input  logic            s_pulse_i,
  output logic            s_ready_o,
  input  logic            m_ready_i,
  output logic            m_valid_o,
  output logic [IdxW-1:0] m_index_o,
  output logic [ChW-1:0]  m_red_o,
  output logic [ChW-1:0]  m_green_o,
  output logic [ChW-1:0]  m_blue_o,
  output logic            m_last_o,
  output mdu_req_t        mdu_req_o,
  input  mdu_rsp_t        mdu_rsp_i
);

  localparam logic [IdxW:0]   NPix    = (IdxW+1)'(PIXELS);
  localparam logic [IdxW-1:0] LastPix = IdxW'(PIXELS - 1);

  seq_state_e state_q, state_d;
  logic            wait_q;
  logic            chase_q;
  logic [PctW-1:0] br_q;
  logic [5:0]      lvl_q;
  logic [ChW-1:0]  cw_q;
  logic            sub_q;
  logic [TailW-1:0] t_q;
  logic [1:0]      ch_q;
  logic [IdxW-1:0] pix_q;
  logic [IdxW-1:0] head_q;
  logic [ChW-1:0]  ic_q [NumCh];
  logic [ChW-1:0]  tv_q [TailLen][NumCh];

  logic            m_valid_q, m_last_q;
  logic [IdxW-1:0] m_index_q;
  logic [ChW-1:0]  m_red_q, m_green_q, m_blue_q;

  logic            accept, in_op, capture, load_out, last_pix;
  logic [ChW-1:0]  idle_c, pulse_c;
  logic [IdxW:0]   behind_raw, behind;
  logic            in_tail;
  logic [TailW-1:0] tidx;
  logic [ChW-1:0]  px_r, px_g, px_b;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i & s_ready_o;
  assign in_op     = (state_q == ST_BR) | (state_q == ST_LVL) | (state_q == ST_CALC);
  assign capture   = in_op & wait_q & mdu_rsp_i.done;
  assign load_out  = (state_q == ST_EMIT) & (~m_valid_q | m_ready_i);
  assign last_pix  = (pix_q == LastPix);

  always_comb begin
    case (ch_q)
      2'd0:    begin idle_c = cfg_i.idle_red;   pulse_c = cfg_i.pulse_red;   end
      2'd1:    begin idle_c = cfg_i.idle_green; pulse_c = cfg_i.pulse_green; end
      default: begin idle_c = cfg_i.idle_blue;  pulse_c = cfg_i.pulse_blue;  end
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    mdu_req_o.go  = in_op & ~wait_q;
    mdu_req_o.sel = DIV_BY_100;
    mdu_req_o.a   = '0;
    mdu_req_o.b   = '0;
    case (state_q)
      ST_BR: begin
        mdu_req_o.a = {1'b0, cfg_i.brightness};
        mdu_req_o.b = {1'b0, cfg_i.board_scale};
      end
      ST_LVL: begin
        mdu_req_o.a = {1'b0, br_q};
        mdu_req_o.b = ChaseLevel;
      end
      ST_CALC: begin
        if (!chase_q) begin
          mdu_req_o.a = idle_c;
          mdu_req_o.b = {1'b0, br_q};
        end else if (!sub_q) begin
          mdu_req_o.sel = DIV_BY_255;
          mdu_req_o.a   = pulse_c;
          mdu_req_o.b   = tail_weight(t_q);
        end else begin
          mdu_req_o.a = cw_q;
          mdu_req_o.b = {2'b0, lvl_q};
        end
      end
      default: ;
    endcase
  end

  // distance behind the head, one wrap correction
  assign behind_raw = {1'b0, head_q} + NPix - {1'b0, pix_q};
  assign behind     = (behind_raw >= NPix) ? behind_raw - NPix : behind_raw;
  assign in_tail    = (behind < (IdxW+1)'(TailLen));
  assign tidx       = behind[TailW-1:0];

  always_comb begin
    if (!chase_q) begin
      px_r = ic_q[0];
      px_g = ic_q[1];
      px_b = ic_q[2];
    end else if (in_tail) begin
      px_r = tv_q[tidx][0];
      px_g = tv_q[tidx][1];
      px_b = tv_q[tidx][2];
    end else begin
      px_r = '0;
      px_g = '0;
      px_b = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_BR;
      ST_BR:   if (capture) state_d = ST_LVL;
      ST_LVL:  if (capture) state_d = ST_CALC;
      ST_CALC: begin
        if (capture && ch_q == 2'd2) begin
          if (!chase_q) state_d = ST_EMIT;
          else if (sub_q && t_q == TailW'(TailLen - 1)) state_d = ST_EMIT;
        end
      end
      ST_EMIT: if (load_out && last_pix) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wait_q    <= 1'b0;
      head_q    <= '0;
      m_valid_q <= 1'b0;
      sub_q     <= 1'b0;
      t_q       <= '0;
      ch_q      <= '0;
      pix_q     <= '0;
      chase_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        chase_q <= s_pulse_i;
        wait_q  <= 1'b0;
      end else if (in_op && !wait_q) begin
        wait_q <= 1'b1;
      end else if (capture) begin
        wait_q <= 1'b0;
      end

      if (capture && state_q == ST_LVL) begin
        t_q   <= '0;
        ch_q  <= '0;
        sub_q <= 1'b0;
      end else if (capture && state_q == ST_CALC) begin
        if (!chase_q || sub_q) begin
          ch_q <= (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
          if (chase_q && ch_q == 2'd2) t_q <= t_q + TailW'(1);
        end
        if (chase_q) sub_q <= ~sub_q;
        if (state_d == ST_EMIT) pix_q <= '0;
      end

      if (load_out) begin
        m_valid_q <= 1'b1;
        pix_q     <= pix_q + IdxW'(1);
        if (last_pix && chase_q) head_q <= (head_q == LastPix) ? '0 : head_q + IdxW'(1);
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      case (state_q)
        ST_BR:  br_q  <= mdu_rsp_i.q[PctW-1:0];
        ST_LVL: lvl_q <= mdu_rsp_i.q[5:0];
        ST_CALC: begin
          if (!chase_q)    ic_q[ch_q]      <= mdu_rsp_i.q;
          else if (!sub_q) cw_q            <= mdu_rsp_i.q;
          else             tv_q[t_q][ch_q] <= mdu_rsp_i.q;
        end
        default: ;
      endcase
    end
    if (load_out) begin
      m_index_q <= pix_q;
      m_red_q   <= px_r;
      m_green_q <= px_g;
      m_blue_q  <= px_b;
      m_last_q  <= last_pix;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_index_o = m_index_q;
  assign m_red_o   = m_red_q;
  assign m_green_o = m_green_q;
  assign m_blue_o  = m_blue_q;
  assign m_last_o  = m_last_q;

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < NPix[IdxW-1:0] || NPix == (IdxW+1)'(64))
    else $error("head position out of ring");

  a_head_moves_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(head_q) |-> $past(load_out && last_pix && chase_q))
    else $error("head moved outside the end of a chase frame");

  a_unit_not_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_req_o.go |=> !mdu_req_o.go)
    else $error("arithmetic unit issued while busy");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_last_q) |-> (m_index_q == LastPix))
    else $error("last flag on wrong pixel");

endmodule
